FILE: src/gaussian_noise_generator_assert.svh
// assertion macros shared by the block
`ifndef GAUSSIAN_NOISE_GENERATOR_ASSERT_SVH
`define GAUSSIAN_NOISE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define GNG_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GNG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/gng_pkg.sv
package gng_pkg;

   localparam int FRAC_BITS_DEFAULT = 11;
   localparam logic [63:0] SEED_RESET = 64'd1;
   localparam logic [63:0] SEED_DEFAULT = 64'h9E3779B97F4A7C15;
   localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
   localparam logic [30:0] PI_Q29 = 31'd1686629713;
   localparam logic signed [33:0] CORDIC_K = 34'sd652032875;
   localparam logic [31:0] QUARTER_PI_Q30 = 32'd843314857;

   localparam int LOG_STEPS = 24;
   localparam int SQRT_STEPS = 20;
   localparam int CORDIC_STEPS = 30;
   localparam int CNT_W = 5;

   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic      draw_first;
      logic      draw_second;
      logic      norm;
      logic      log_step;
      logic      prep;
      logic      rot_step;
      logic      scale;
      logic      finish;
      logic      give_spare;
      count_type cnt;
   } cmd_type;

   typedef logic [31:0] atan_table_type [CORDIC_STEPS];

   // series term divided by the odd number 2k+1
   function automatic logic [63:0] odd_div(logic [63:0] v, int unsigned k);
      case (k)
         0: return v;
         1: return v / 64'd3;
         2: return v / 64'd5;
         3: return v / 64'd7;
         4: return v / 64'd9;
         5: return v / 64'd11;
         6: return v / 64'd13;
         7: return v / 64'd15;
         8: return v / 64'd17;
         9: return v / 64'd19;
         10: return v / 64'd21;
         11: return v / 64'd23;
         12: return v / 64'd25;
         13: return v / 64'd27;
         14: return v / 64'd29;
         15: return v / 64'd31;
         16: return v / 64'd33;
         17: return v / 64'd35;
         18: return v / 64'd37;
         19: return v / 64'd39;
         20: return v / 64'd41;
         21: return v / 64'd43;
         22: return v / 64'd45;
         23: return v / 64'd47;
         24: return v / 64'd49;
         25: return v / 64'd51;
         26: return v / 64'd53;
         27: return v / 64'd55;
         28: return v / 64'd57;
         29: return v / 64'd59;
         30: return v / 64'd61;
         default: return 64'd0;
      endcase
   endfunction

   function automatic logic [31:0] atan_entry(int unsigned i);
      logic [63:0] sum;
      logic [63:0] t;
      logic [63:0] rnd;
      int unsigned e;
      sum = 64'd0;
      if (i == 0) begin
         return QUARTER_PI_Q30;
      end
      for (int unsigned k = 0; k < 32; k++) begin
         e = i * (2 * k + 1);
         if (e <= 62) begin
            t = odd_div(64'd1 << (62 - e), k);
            if (k % 2 == 1) begin
               sum = sum - t;
            end else begin
               sum = sum + t;
            end
         end
      end
      rnd = (sum + (64'd1 << 31)) >> 32;
      return rnd[31:0];
   endfunction

   function automatic atan_table_type build_atan();
      atan_table_type tab;
      for (int unsigned i = 0; i < CORDIC_STEPS; i++) begin
         tab[i] = atan_entry(i);
      end
      return tab;
   endfunction

   localparam atan_table_type ATAN_TABLE = build_atan();

endpackage

FILE: src/gng_ctrl.sv
module gng_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_request,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             spare_ready,
   output gng_pkg::cmd_type cmd
);
   import gng_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DRAW1 = 4'd1;
   localparam logic [3:0] S_DRAW2 = 4'd2;
   localparam logic [3:0] S_NORM  = 4'd3;
   localparam logic [3:0] S_LOG   = 4'd4;
   localparam logic [3:0] S_PREP  = 4'd5;
   localparam logic [3:0] S_ROT   = 4'd6;
   localparam logic [3:0] S_SCALE = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;

   logic [3:0] state_ff, state_in;
   count_type  cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.cnt = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_request) begin
               if (spare_ready) begin
                  cmd.give_spare = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_DRAW1;
               end
            end
         end
         S_DRAW1: begin
            cmd.draw_first = 1'b1;
            state_in = S_DRAW2;
         end
         S_DRAW2: begin
            cmd.draw_second = 1'b1;
            state_in = S_NORM;
         end
         S_NORM: begin
            cmd.norm = 1'b1;
            cnt_in = '0;
            state_in = S_LOG;
         end
         S_LOG: begin
            cmd.log_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LOG_STEPS - 1)) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            cnt_in = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            cmd.rot_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`include "gaussian_noise_generator_assert.svh"

   `GNG_ASSERT_NEXT(a_log_to_prep, state_ff == S_LOG && cnt_ff == CNT_W'(LOG_STEPS - 1), state_ff == S_PREP, "log phase overran")
   `GNG_ASSERT_IMPL(a_busy_no_rsp, state_ff != S_IDLE, !rsp_valid_ff, "result pending while busy")
   `GNG_ASSERT_IMPL(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff) == S_FIN || $past(state_ff) == S_IDLE, "result from wrong state")
   `GNG_ASSERT_IMPL(a_rot_count, state_ff == S_ROT, cnt_ff < CNT_W'(CORDIC_STEPS), "rotation count out of range")

endmodule

FILE: src/gng_dp.sv
module gng_dp #(
   parameter int FRAC_BITS = gng_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic [63:0]      csr_wdata,
   input  gng_pkg::cmd_type cmd,
   output logic             spare_ready,
   output logic signed [15:0] rsp_sample,
   output logic             rsp_from_sine
);
   import gng_pkg::*;

   localparam int SH = 46 - FRAC_BITS;
   localparam int LIM_RAW = 10 << FRAC_BITS;
   localparam logic [15:0] LIM = (LIM_RAW > 32767) ? 16'd32767 : 16'(LIM_RAW);

   logic [63:0] rng_ff, rng_in;
   logic        spare_ready_ff, spare_ready_in;
   logic [31:0] m_ff, u2_ff;
   logic [4:0]  p_ff;
   logic [31:0] x_ff;
   logic [23:0] frac_ff;
   logic [39:0] sqv_ff, sqres_ff;
   logic signed [33:0] cx_ff, cy_ff, z_ff;
   logic [1:0]  q_ff;
   logic [53:0] prod_c_ff, prod_s_ff;
   logic        neg_c_ff, neg_s_ff;
   logic [15:0] spare_ff;
   logic signed [15:0] sample_ff;
   logic        from_sine_ff;

   logic [63:0] d1, d2, d3;
   logic [31:0] mnz, xn;
   logic [4:0]  pn;
   logic [63:0] sq;
   logic [32:0] y;
   logic [29:0] lval;
   logic [60:0] r2p;
   logic [60:0] r2s;
   logic [31:0] qsum, dw, dmag;
   logic [60:0] zp;
   logic [30:0] zm;
   logic signed [33:0] zn;
   logic signed [33:0] xs, ys, at;
   logic [39:0] sbit, trial;
   logic signed [33:0] cv, sv;
   logic [33:0] cmag, smag;
   logic [15:0] cos_out, sin_out;

   function automatic logic [15:0] round_sat(logic [53:0] p, logic n);
      logic [53:0] rc;
      logic [53:0] mag;
      logic [15:0] sat;
      rc = p + (54'd1 << (SH - 1));
      mag = rc >> SH;
      sat = (mag > {38'd0, LIM}) ? LIM : mag[15:0];
      return n ? 16'(-sat) : sat;
   endfunction

   always_comb begin
      d1 = rng_ff ^ (rng_ff << 13);
      d2 = d1 ^ (d1 >> 17);
      d3 = d2 ^ (d2 << 5);

      mnz = (m_ff == 32'd0) ? 32'd1 : m_ff;
      pn = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mnz[i]) begin
            pn = 5'(i);
         end
      end
      xn = mnz << (5'd31 - pn);

      sq = {32'd0, x_ff} * {32'd0, x_ff};
      y = sq[63:31];

      lval = {(6'd32 - {1'b0, p_ff}), 24'd0} - {6'd0, frac_ff};
      r2p = {31'd0, lval} * {30'd0, TWO_LN2_Q30};
      r2s = r2p + (61'd1 << 29);

      qsum = u2_ff + 32'h20000000;
      dw = u2_ff - {qsum[31:30], 30'd0};
      dmag = dw[31] ? 32'(-dw) : dw;
      zp = {31'd0, dmag[29:0]} * {30'd0, PI_Q29};
      zm = 31'((zp + (61'd1 << 29)) >> 30);
      zn = dw[31] ? -$signed({3'd0, zm}) : $signed({3'd0, zm});

      xs = cx_ff >>> cmd.cnt;
      ys = cy_ff >>> cmd.cnt;
      at = $signed({2'd0, ATAN_TABLE[cmd.cnt]});
      sbit = 40'd1 << (6'd38 - {cmd.cnt, 1'b0});
      trial = sqres_ff + sbit;

      case (q_ff)
         2'd0: begin
            cv = cx_ff;
            sv = cy_ff;
         end
         2'd1: begin
            cv = -cy_ff;
            sv = cx_ff;
         end
         2'd2: begin
            cv = -cx_ff;
            sv = -cy_ff;
         end
         default: begin
            cv = cy_ff;
            sv = -cx_ff;
         end
      endcase
      cmag = cv[33] ? 34'(-cv) : 34'(cv);
      smag = sv[33] ? 34'(-sv) : 34'(sv);

      cos_out = round_sat(prod_c_ff, neg_c_ff);
      sin_out = round_sat(prod_s_ff, neg_s_ff);

      rng_in = rng_ff;
      if (csr_wen) begin
         rng_in = (csr_wdata == 64'd0) ? SEED_DEFAULT : csr_wdata;
      end else if (cmd.draw_first || cmd.draw_second) begin
         rng_in = d3;
      end

      spare_ready_in = spare_ready_ff;
      if (csr_wen || cmd.give_spare) begin
         spare_ready_in = 1'b0;
      end else if (cmd.finish) begin
         spare_ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_ff <= SEED_RESET;
         spare_ready_ff <= 1'b0;
      end else begin
         rng_ff <= rng_in;
         spare_ready_ff <= spare_ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.draw_first) begin
         m_ff <= d3[63:32];
      end
      if (cmd.draw_second) begin
         u2_ff <= d3[63:32];
      end
      if (cmd.norm) begin
         p_ff <= pn;
         x_ff <= xn;
         frac_ff <= '0;
      end
      if (cmd.log_step) begin
         x_ff <= y[32] ? y[32:1] : y[31:0];
         frac_ff <= {frac_ff[22:0], y[32]};
      end
      if (cmd.prep) begin
         sqv_ff <= {2'd0, r2s[59:30], 8'd0};
         sqres_ff <= '0;
         q_ff <= qsum[31:30];
         z_ff <= zn;
         cx_ff <= CORDIC_K;
         cy_ff <= '0;
      end
      if (cmd.rot_step) begin
         if (z_ff >= 0) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            z_ff <= z_ff + at;
         end
         if (cmd.cnt < CNT_W'(SQRT_STEPS)) begin
            if (sqv_ff >= trial) begin
               sqv_ff <= sqv_ff - trial;
               sqres_ff <= (sqres_ff >> 1) + sbit;
            end else begin
               sqres_ff <= sqres_ff >> 1;
            end
         end
      end
      if (cmd.scale) begin
         prod_c_ff <= {34'd0, sqres_ff[19:0]} * {20'd0, cmag};
         prod_s_ff <= {34'd0, sqres_ff[19:0]} * {20'd0, smag};
         neg_c_ff <= cv[33];
         neg_s_ff <= sv[33];
      end
      if (cmd.finish) begin
         sample_ff <= $signed(cos_out);
         from_sine_ff <= 1'b0;
         spare_ff <= sin_out;
      end
      if (cmd.give_spare) begin
         sample_ff <= $signed(spare_ff);
         from_sine_ff <= 1'b1;
      end
   end

   assign spare_ready = spare_ready_ff;
   assign rsp_sample = sample_ff;
   assign rsp_from_sine = from_sine_ff;

endmodule

FILE: src/gaussian_noise_generator.sv
// Gaussian noise generator: Box-Muller over a 64-bit xorshift source.
// Input channel req_valid/req_ready/req_request: a transaction with request
// set asks for one sample; with request clear it is taken and gives nothing.
// Result channel rsp_valid/rsp_ready: rsp_sample is signed fixed point with
// FRAC_BITS fraction bits, rsp_from_sine marks the held sine half of a pair.
// csr_wen/csr_wdata load the seed (zero selects a fixed default) and drop
// any held spare; write only while the block is idle.
// A request that makes a pair gives its cosine sample after two draws,
// normalise, 24 log squarings, 30 CORDIC iterations with the square-root
// steps run in the same loop, scale and round. A request served from the
// spare gives its sample in the cycle after acceptance. The sustained
// rate is set by the log and CORDIC loops.
// One transaction is in flight at a time; the result waits in the output
// register while the receiver stalls and req_ready stays low until taken.
// Reset loads seed 1, clears the spare and any pending result.
module gaussian_noise_generator #(
   parameter int FRAC_BITS = gng_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_request,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_from_sine,
   input  logic               csr_wen,
   input  logic [63:0]        csr_wdata
);
   import gng_pkg::*;

   cmd_type cmd;
   logic    spare_ready;

   gng_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_request (req_request),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .spare_ready (spare_ready),
      .cmd         (cmd)
   );

   gng_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .spare_ready   (spare_ready),
      .rsp_sample    (rsp_sample),
      .rsp_from_sine (rsp_from_sine)
   );

endmodule

FILE: bench/gaussian_noise_generator_tb.sv
`timescale 1ns / 1ps

module gaussian_noise_generator_tb;
   import gng_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam int SETTLE = 70;
   localparam int WATCHDOG = 5000;
   localparam int SQUEEZE_LEN = 300;

   typedef struct {
      logic signed [15:0] sample;
      bit                 sine;
   } sample_rec;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_request;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_sample;
   logic               rsp_from_sine;
   logic               csr_wen;
   logic [63:0]        csr_wdata;

   bit        request_q[$];
   sample_rec sample_q[$];

   bit [63:0] rng_word;
   bit [15:0] spare_word;
   bit        spare_held;
   longint    atan_tab[CORDIC_STEPS];

   int  mismatches;
   bit  quiet;
   bit  squeeze;
   bit  squeeze_done;
   int  gap_left;
   int  stall_left;
   int  hold_left;
   int  idle_cycles;

   gaussian_noise_generator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_request(req_request),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sample(rsp_sample), .rsp_from_sine(rsp_from_sine),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit [63:0] xorshift_next();
      bit [63:0] x;
      x = rng_word;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      rng_word = x;
      return x;
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic bit [15:0] to_output(bit [63:0] r, longint t);
      int        sh;
      bit [63:0] lim;
      bit [63:0] mag;
      bit        neg;
      sh = 46 - FRAC;
      lim = (10 << FRAC) > 32767 ? 64'd32767 : 64'(10 << FRAC);
      neg = t < 0;
      mag = neg ? 64'(-t) : 64'(t);
      mag = (r * mag + (64'd1 << (sh - 1))) >> sh;
      if (mag > lim) mag = lim;
      return neg ? 16'(-mag) : 16'(mag);
   endfunction

   function automatic void build_atan_tab();
      bit [63:0] sum;
      int        e;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         sum = 0;
         for (int k = 0; k < 40; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
               if (k % 2 == 1) sum = sum - ((64'd1 << (62 - e)) / 64'(2 * k + 1));
               else sum = sum + ((64'd1 << (62 - e)) / 64'(2 * k + 1));
            end
         end
         atan_tab[i] = (i == 0) ? longint'(QUARTER_PI_Q30) : longint'((sum + (64'd1 << 31)) >> 32);
      end
   endfunction

   function automatic void load_seed(bit [63:0] s);
      rng_word = (s != 0) ? s : SEED_DEFAULT;
      spare_word = 0;
      spare_held = 0;
   endfunction

   // box-muller pair from two draws, cosine half queued, sine half held; a held sine half is served first
   function automatic void predict_sample(bit rq);
      bit [31:0] m, u2, dw;
      bit [63:0] x, frac, len, r2, r, dmag, zmag;
      int        p;
      bit [1:0]  q;
      longint    d, z, cx, cy, xs, ys, c, s;
      sample_rec rec;
      if (!rq) return;
      if (spare_held) begin
         rec.sample = spare_word;
         rec.sine = 1;
         sample_q.push_back(rec);
         spare_held = 0;
         return;
      end
      m = xorshift_next() >> 32;
      u2 = xorshift_next() >> 32;
      if (m == 0) m = 1;
      p = 31;
      while (m[p] == 0) p--;
      x = 64'(m) << (31 - p);
      frac = 0;
      for (int i = 0; i < 24; i++) begin
         x = (x * x) >> 31;
         frac = frac << 1;
         if (x >= (64'd1 << 32)) begin
            x = x >> 1;
            frac = frac | 1;
         end
      end
      len = (64'(32 - p) << 24) - frac;
      r2 = (len * 64'(TWO_LN2_Q30) + (64'd1 << 29)) >> 30;
      r = int_sqrt(r2 << 8);
      q = 2'((u2 + 32'h2000_0000) >> 30);
      dw = u2 - (32'(q) << 30);
      d = longint'(signed'(dw));
      dmag = d < 0 ? 64'(-d) : 64'(d);
      zmag = (dmag * 64'(PI_Q29) + (64'd1 << 29)) >> 30;
      z = d < 0 ? -longint'(zmag) : longint'(zmag);
      cx = longint'(CORDIC_K);
      cy = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (z >= 0) begin
            cx = cx - ys;
            cy = cy + xs;
            z = z - atan_tab[i];
         end else begin
            cx = cx + ys;
            cy = cy - xs;
            z = z + atan_tab[i];
         end
      end
      case (q)
         2'd0: begin c = cx; s = cy; end
         2'd1: begin c = -cy; s = cx; end
         2'd2: begin c = -cx; s = -cy; end
         default: begin c = cy; s = -cx; end
      endcase
      rec.sample = to_output(r, c);
      rec.sine = 0;
      sample_q.push_back(rec);
      spare_word = to_output(r, s);
      spare_held = 1;
   endfunction

   // request driver
   always @(posedge clock) begin
      bit nv;
      bit taken;
      if (reset) begin
         req_valid <= 0;
         gap_left = 0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) predict_sample(req_request);
         if (!req_valid || taken) begin
            nv = 0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_q.size() > 0) begin
               nv = 1;
               req_request <= request_q.pop_front();
               if (!quiet && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 5);
            end
            req_valid <= nv;
         end
      end
   end

   // sample monitor
   always @(posedge clock) begin
      sample_rec exp_rec;
      if (reset) begin
         rsp_ready <= 0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sample_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected sample %0d sine %0b", rsp_sample, rsp_from_sine);
            end else begin
               exp_rec = sample_q.pop_front();
               if (rsp_sample !== exp_rec.sample || rsp_from_sine !== exp_rec.sine) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sample mismatch: expected %0d sine %0b, got %0d sine %0b",
                              exp_rec.sample, exp_rec.sine, rsp_sample, rsp_from_sine);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else if (squeeze && !squeeze_done) begin
            squeeze_done = 1;
            hold_left = SQUEEZE_LEN;
            rsp_ready <= 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            if (!quiet && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 5);
         end
      end
   end

   // no transaction for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wen || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic drain();
      while (request_q.size() > 0 || req_valid || sample_q.size() > 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_seed(bit [63:0] s);
      @(posedge clock);
      csr_wen <= 1;
      csr_wdata <= s;
      load_seed(s);
      @(posedge clock);
      csr_wen <= 0;
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) request_q.push_back($urandom_range(0, 6) != 0);
   endtask

   initial begin
      bit [63:0] seeds[6];
      clock = 0;
      reset = 1;
      req_valid = 0;
      req_request = 0;
      rsp_ready = 0;
      csr_wen = 0;
      csr_wdata = 0;
      mismatches = 0;
      idle_cycles = 0;
      quiet = 0;
      squeeze = 0;
      squeeze_done = 0;
      build_atan_tab();
      load_seed(SEED_RESET);
      repeat (11) @(posedge clock);
      reset <= 0;

      // reset seed gives a zero top word on the first draw
      foreach (seeds[i]) seeds[i] = 0;
      request_q.push_back(0);
      request_q.push_back(1);
      request_q.push_back(1);
      request_q.push_back(1);
      request_q.push_back(0);
      request_q.push_back(1);
      request_q.push_back(1);
      drain();
      // held spare served here; a spare held later is dropped by a new seed
      request_q.push_back(1);
      drain();
      write_seed(64'd0);
      request_q.push_back(1);
      request_q.push_back(1);
      request_q.push_back(1);
      drain();
      write_seed(64'hFFFF_FFFF_FFFF_FFFF);
      request_q.push_back(1);
      request_q.push_back(0);
      request_q.push_back(1);
      request_q.push_back(1);
      drain();
      write_seed(64'h8000_0000_0000_0000);
      request_q.push_back(1);
      request_q.push_back(1);
      drain();

      seeds[0] = 64'd1;
      seeds[1] = {$urandom, $urandom};
      seeds[2] = 64'hFFFF_FFFF_FFFF_FFFF;
      seeds[3] = {$urandom, $urandom};
      seeds[4] = 64'd0;
      seeds[5] = {$urandom, $urandom};
      for (int ph = 0; ph < 6; ph++) begin
         write_seed(seeds[ph]);
         if (ph == 5) quiet = 1;
         queue_random(255);
         if (ph == 2) begin
            repeat (200) @(posedge clock);
            squeeze = 1;
         end
         drain();
      end

      if (mismatches == 0 && sample_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
